// ===== design/fqa_pkg.sv =====
package fqa_pkg;

    localparam int FRAC_BITS = 8;
    localparam int DATA_W    = 32;
    localparam int NUM_W     = DATA_W + FRAC_BITS;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int Q_W       = PROD_W + 1;

    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_MIN      = 4'd4,
        OP_MAX      = 4'd5,
        OP_INC      = 4'd6,
        OP_DEC      = 4'd7,
        OP_FROM_INT = 4'd8,
        OP_TO_INT   = 4'd9
    } t_op;

    typedef enum logic [1:0] {
        K_DIRECT,
        K_MUL,
        K_DIV
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               neg;
        logic [DATA_W-1:0]  res;
        logic               ovf;
        logic               dz;
        logic               gt;
        logic               lt;
        logic               eq;
        logic [PROD_W-1:0]  prod;
        logic [DATA_W-1:0]  mb;
        logic [NUM_W-1:0]   num;
        logic [DATA_W-1:0]  rem;
        logic [NUM_W-1:0]   quo;
    } t_item;

    typedef struct packed {
        logic [DATA_W-1:0] val;
        logic              ovf;
    } t_sat;

    function automatic t_sat sat_wide(input logic [DATA_W:0] s);
        t_sat r;
        r.ovf = s[DATA_W] != s[DATA_W-1];
        r.val = r.ovf ? (s[DATA_W] ? SAT_MIN : SAT_MAX) : s[DATA_W-1:0];
        return r;
    endfunction

endpackage

// ===== design/fqa_front.sv =====
module fqa_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [3:0]                    i_op,
    input  logic signed [fqa_pkg::DATA_W-1:0] i_operand_a,
    input  logic signed [fqa_pkg::DATA_W-1:0] i_operand_b,
    output logic                          o_valid,
    output fqa_pkg::t_item                o_item
);
    import fqa_pkg::*;

    logic [DATA_W:0]   a_x;
    logic [DATA_W:0]   b_x;
    logic [DATA_W-1:0] ma;
    logic [DATA_W-1:0] mb;
    logic [NUM_W-1:0]  a_sh;
    logic              fi_ovf;
    t_sat              s_add;
    t_sat              s_sub;
    t_sat              s_inc;
    t_sat              s_dec;
    t_item             n_item;
    logic              r_valid;
    t_item             r_item;

    always_comb begin
        a_x    = {i_operand_a[DATA_W-1], i_operand_a};
        b_x    = {i_operand_b[DATA_W-1], i_operand_b};
        ma     = i_operand_a[DATA_W-1] ? (~i_operand_a + 1'b1) : i_operand_a;
        mb     = i_operand_b[DATA_W-1] ? (~i_operand_b + 1'b1) : i_operand_b;
        s_add  = sat_wide(a_x + b_x);
        s_sub  = sat_wide(a_x - b_x);
        s_inc  = sat_wide(a_x + {{DATA_W{1'b0}}, 1'b1});
        s_dec  = sat_wide(a_x - {{DATA_W{1'b0}}, 1'b1});
        a_sh   = {{FRAC_BITS{i_operand_a[DATA_W-1]}}, i_operand_a} << FRAC_BITS;
        fi_ovf = !((&a_sh[NUM_W-1:DATA_W-1]) || !(|a_sh[NUM_W-1:DATA_W-1]));

        n_item      = '0;
        n_item.kind = K_DIRECT;
        n_item.neg  = i_operand_a[DATA_W-1] != i_operand_b[DATA_W-1];
        n_item.gt   = i_operand_a > i_operand_b;
        n_item.lt   = i_operand_a < i_operand_b;
        n_item.eq   = i_operand_a == i_operand_b;
        n_item.prod = PROD_W'(ma) * PROD_W'(mb);
        n_item.mb   = mb;
        n_item.num  = NUM_W'(ma) << FRAC_BITS;

        unique case (i_op)
            OP_ADD: begin
                n_item.res = s_add.val;
                n_item.ovf = s_add.ovf;
            end
            OP_SUB: begin
                n_item.res = s_sub.val;
                n_item.ovf = s_sub.ovf;
            end
            OP_MUL: begin
                n_item.kind = K_MUL;
            end
            OP_DIV: begin
                if (mb == '0) begin
                    n_item.dz  = 1'b1;
                    n_item.res = i_operand_a[DATA_W-1] ? SAT_MIN : SAT_MAX;
                end else begin
                    n_item.kind = K_DIV;
                end
            end
            OP_MIN: begin
                n_item.res = (i_operand_a > i_operand_b) ? i_operand_b : i_operand_a;
            end
            OP_MAX: begin
                n_item.res = (i_operand_a < i_operand_b) ? i_operand_b : i_operand_a;
            end
            OP_INC: begin
                n_item.res = s_inc.val;
                n_item.ovf = s_inc.ovf;
            end
            OP_DEC: begin
                n_item.res = s_dec.val;
                n_item.ovf = s_dec.ovf;
            end
            OP_FROM_INT: begin
                n_item.ovf = fi_ovf;
                n_item.res = fi_ovf ? (i_operand_a[DATA_W-1] ? SAT_MIN : SAT_MAX)
                                    : a_sh[DATA_W-1:0];
            end
            OP_TO_INT: begin
                n_item.res = i_operand_a >>> FRAC_BITS;
            end
            default: begin
                n_item.res = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== design/fqa_div_cell.sv =====
module fqa_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  fqa_pkg::t_item i_item,
    output logic           o_valid,
    output fqa_pkg::t_item o_item
);
    import fqa_pkg::*;

    logic [DATA_W:0] rem_sh;
    logic [DATA_W:0] rem_sub;
    logic            ge;
    t_item           n_item;
    logic            r_valid;
    t_item           r_item;

    always_comb begin
        rem_sh      = {i_item.rem, i_item.num[NUM_W-1]};
        rem_sub     = rem_sh - {1'b0, i_item.mb};
        ge          = rem_sh >= {1'b0, i_item.mb};
        n_item      = i_item;
        n_item.rem  = ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
        n_item.num  = {i_item.num[NUM_W-2:0], 1'b0};
        n_item.quo  = {i_item.quo[NUM_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== design/fqa_back.sv =====
module fqa_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  fqa_pkg::t_item                    i_item,
    output logic                              o_valid,
    output logic signed [fqa_pkg::DATA_W-1:0] o_result,
    output logic                              o_a_greater,
    output logic                              o_a_less,
    output logic                              o_a_equal,
    output logic                              o_overflow,
    output logic                              o_divide_by_zero
);
    import fqa_pkg::*;

    logic [Q_W-1:0]    q_mul;
    logic [Q_W-1:0]    q_div;
    logic [Q_W-1:0]    q;
    logic              rup;
    logic [DATA_W-1:0] n_res;
    logic              n_ovf;
    logic              r_valid;
    logic [DATA_W-1:0] r_res;
    logic              r_gt;
    logic              r_lt;
    logic              r_eq;
    logic              r_ovf;
    logic              r_dz;

    always_comb begin
        q_mul = (Q_W'(i_item.prod) + (Q_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        rup   = {i_item.rem, 1'b0} >= {1'b0, i_item.mb};
        q_div = Q_W'(i_item.quo) + Q_W'(rup);
        q     = (i_item.kind == K_MUL) ? q_mul : q_div;
        n_res = i_item.res;
        n_ovf = i_item.ovf;
        if (i_item.kind != K_DIRECT) begin
            if (i_item.neg) begin
                n_ovf = q > Q_W'(SAT_MIN);
                n_res = n_ovf ? SAT_MIN : (~q[DATA_W-1:0] + 1'b1);
            end else begin
                n_ovf = q > Q_W'(SAT_MAX);
                n_res = n_ovf ? SAT_MAX : q[DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
            r_ovf <= n_ovf;
            r_dz  <= i_item.dz;
            r_gt  <= i_item.gt;
            r_lt  <= i_item.lt;
            r_eq  <= i_item.eq;
        end
    end

    assign o_valid          = r_valid;
    assign o_result         = r_res;
    assign o_a_greater      = r_gt;
    assign o_a_less         = r_lt;
    assign o_a_equal        = r_eq;
    assign o_overflow       = r_ovf;
    assign o_divide_by_zero = r_dz;

endmodule

// ===== design/fixed_point_q24_8_alu.sv =====
// Pipeline: one operand stage, 40 divider cells and an output stage from request to result.
// Accepts one request per cycle while o_stall is low; every op walks the same chain of restoring
// divider cells, each cell producing one quotient bit.
// The whole chain advances together and halts only while a result is held at the output.
// Reset is synchronous and active low; it clears all valid bits, payload registers are not reset.
module fixed_point_q24_8_alu (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [3:0]                        i_op,
    input  logic signed [fqa_pkg::DATA_W-1:0] i_operand_a,
    input  logic signed [fqa_pkg::DATA_W-1:0] i_operand_b,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [fqa_pkg::DATA_W-1:0] o_result,
    output logic                              o_a_greater,
    output logic                              o_a_less,
    output logic                              o_a_equal,
    output logic                              o_overflow,
    output logic                              o_divide_by_zero
);
    import fqa_pkg::*;

    logic  adv;
    logic  v_chain [NUM_W+1];
    t_item i_chain [NUM_W+1];

    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    fqa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (adv),
        .i_valid     (i_valid),
        .i_op        (i_op),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_valid     (v_chain[0]),
        .o_item      (i_chain[0])
    );

    for (genvar g = 0; g < NUM_W; g++) begin : g_cell
        fqa_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (v_chain[g]),
            .i_item  (i_chain[g]),
            .o_valid (v_chain[g+1]),
            .o_item  (i_chain[g+1])
        );
    end

    fqa_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (adv),
        .i_valid          (v_chain[NUM_W]),
        .i_item           (i_chain[NUM_W]),
        .o_valid          (o_valid),
        .o_result         (o_result),
        .o_a_greater      (o_a_greater),
        .o_a_less         (o_a_less),
        .o_a_equal        (o_a_equal),
        .o_overflow       (o_overflow),
        .o_divide_by_zero (o_divide_by_zero)
    );

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
    import fqa_pkg::*;

    typedef struct {
        logic [31:0] result;
        logic        gt;
        logic        lt;
        logic        eq;
        logic        ovf;
        logic        dz;
    } t_alu_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [3:0]  i_op = 4'd0;
    logic signed [31:0] i_operand_a = '0;
    logic signed [31:0] i_operand_b = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic signed [31:0] o_result;
    logic        o_a_greater, o_a_less, o_a_equal, o_overflow, o_divide_by_zero;

    t_alu_out    pending_results[$];
    int          mismatch_count = 0;
    int          hold_off_cycles = 0;
    bit          sender_bursty = 1'b0;

    always #2 i_clk = ~i_clk;

    fixed_point_q24_8_alu dut (.*);

    function automatic logic [31:0] saturate(input logic neg, input logic [127:0] mag,
                                             output logic ovf);
        ovf = 1'b0;
        if (neg) begin
            if (mag > 128'h8000_0000) begin
                ovf = 1'b1;
                return SAT_MIN;
            end
            return 32'(-mag);
        end
        if (mag > 128'h7FFF_FFFF) begin
            ovf = 1'b1;
            return SAT_MAX;
        end
        return mag[31:0];
    endfunction

    function automatic logic [127:0] magnitude(input logic signed [127:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic t_alu_out compute_alu(input logic [3:0] op,
                                             input logic signed [31:0] a,
                                             input logic signed [31:0] b);
        t_alu_out r;
        logic signed [127:0] wa, wb;
        logic [127:0] ma, mb, q;
        logic neg;
        wa = a;
        wb = b;
        ma = magnitude(wa);
        mb = magnitude(wb);
        neg = (a < 0) != (b < 0);
        r.ovf = 1'b0;
        r.dz = 1'b0;
        r.result = '0;
        case (op)
            OP_ADD: r.result = saturate(wa + wb < 0, magnitude(wa + wb), r.ovf);
            OP_SUB: r.result = saturate(wa - wb < 0, magnitude(wa - wb), r.ovf);
            OP_MUL: begin
                q = (ma * mb + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                r.result = saturate(neg && q != 0, q, r.ovf);
            end
            OP_DIV: begin
                if (b == 0) begin
                    r.dz = 1'b1;
                    r.result = a < 0 ? SAT_MIN : SAT_MAX;
                end else begin
                    q = (2 * (ma << FRAC_BITS) + mb) / (2 * mb);
                    r.result = saturate(neg && q != 0, q, r.ovf);
                end
            end
            OP_MIN: r.result = a > b ? b : a;
            OP_MAX: r.result = a < b ? b : a;
            OP_INC: r.result = saturate(wa + 1 < 0, magnitude(wa + 1), r.ovf);
            OP_DEC: r.result = saturate(wa - 1 < 0, magnitude(wa - 1), r.ovf);
            OP_FROM_INT: r.result = saturate(a < 0, ma << FRAC_BITS, r.ovf);
            OP_TO_INT: r.result = a >>> FRAC_BITS;
            default: r.result = '0;
        endcase
        r.gt = a > b;
        r.lt = a < b;
        r.eq = a == b;
        return r;
    endfunction

    task automatic send_request(input logic [3:0] op, input logic [31:0] a,
                                input logic [31:0] b);
        int gap;
        if (sender_bursty && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 6);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_op        <= op;
        i_operand_a <= a;
        i_operand_b <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(compute_alu(op, a, b));
        @(negedge i_clk);
    endtask

    task automatic go_idle();
        i_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [31:0] random_operand();
        case ($urandom_range(0, 5))
            0: return {$urandom_range(0, 1) ? 24'hFFFFFF : 24'h0, 8'($urandom)};
            1: return SAT_MAX - $urandom_range(0, 3);
            2: return SAT_MIN + $urandom_range(0, 3);
            3: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] corner[6];
        corner = '{32'h0, 32'h100, 32'hFFFF_FF00, SAT_MAX, SAT_MIN, 32'h80};
        for (int op = 0; op < 16; op++) send_request(4'(op), corner[op % 6], corner[(op + 1) % 6]);
        send_request(OP_DIV, 32'h0, 32'h0);
        send_request(OP_DIV, 32'hFFFF_FFFF, 32'h0);
        send_request(OP_DIV, SAT_MAX, 32'h1);
        send_request(OP_MUL, 32'h180, 32'h80);
        send_request(OP_MUL, 32'hFFFF_FE80, 32'h80);
        send_request(OP_INC, SAT_MAX, 32'h0);
        send_request(OP_DEC, SAT_MIN, 32'h0);
        send_request(OP_TO_INT, 32'hFFFF_FFFF, 32'h5);
        go_idle();
    endtask

    task automatic test_random(input int count);
        logic [3:0] op;
        sender_bursty = 1'b1;
        for (int n = 0; n < count; n++) begin
            op = $urandom_range(0, 15) == 0 ? 4'($urandom_range(10, 15))
                                             : 4'($urandom_range(0, 9));
            send_request(op, random_operand(),
                         $urandom_range(0, 20) == 0 ? 32'h0 : random_operand());
        end
        go_idle();
    endtask

    task automatic test_backpressure();
        hold_off_cycles = 120;
        sender_bursty = 1'b0;
        for (int n = 0; n < 100; n++) send_request(4'($urandom_range(0, 9)), $urandom, $urandom);
        go_idle();
        drain_results();
    endtask

    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            i_stall <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(0, 7) < 2) && ($urandom_range(0, 99) < 70);
        end
    end

    always @(posedge i_clk) begin
        t_alu_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("Unexpected result %h", o_result);
            end else begin
                want = pending_results.pop_front();
                if (o_result !== want.result || o_a_greater !== want.gt ||
                    o_a_less !== want.lt || o_a_equal !== want.eq ||
                    o_overflow !== want.ovf || o_divide_by_zero !== want.dz) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"Mismatch: expected %h %b%b%b ovf=%b dz=%b, ",
                                  "got %h %b%b%b ovf=%b dz=%b"},
                                 want.result, want.gt, want.lt, want.eq, want.ovf, want.dz,
                                 o_result, o_a_greater, o_a_less, o_a_equal,
                                 o_overflow, o_divide_by_zero);
                end
            end
        end
    end

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(500);
        drain_results();
        test_backpressure();
        test_random(700);
        drain_results();
        repeat (60) @(negedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

// ===== filelist.f =====
design/fqa_pkg.sv
design/fqa_front.sv
design/fqa_div_cell.sv
design/fqa_back.sv
design/fixed_point_q24_8_alu.sv
verif/tb_top.sv
